### design/rspf_pkg.sv
// ----------------------------------------------------------------------------
// rspf_pkg
// Shared types, codes and helpers for the serial debug packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package rspf_pkg;

  localparam int unsigned MaxPayloadDefault = 1024;

  localparam int unsigned RxCountWidth = 11;
  localparam int unsigned TxCountWidth = 12;
  localparam int unsigned MaxResults   = 4;

  // input commands
  localparam logic [1:0] CMD_RX_BYTE = 2'd0;
  localparam logic [1:0] CMD_TX_BYTE = 2'd1;
  localparam logic [1:0] CMD_TX_END  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_LINK   = 3'd0;
  localparam logic [2:0] KIND_RXBYTE = 3'd1;
  localparam logic [2:0] KIND_END    = 3'd2;
  localparam logic [2:0] KIND_RETX   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // packet end status
  localparam logic [2:0] ST_GOOD     = 3'd0;
  localparam logic [2:0] ST_BAD_SUM  = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_DANGLING = 3'd4;
  localparam logic [2:0] ST_INTR     = 3'd5;

  // framing characters
  localparam logic [7:0] CH_START  = 8'h24;  // $
  localparam logic [7:0] CH_END    = 8'h23;  // #
  localparam logic [7:0] CH_STAR   = 8'h2a;  // *
  localparam logic [7:0] CH_ESC    = 8'h7d;  // }
  localparam logic [7:0] CH_INTR   = 8'h03;
  localparam logic [7:0] CH_ACK    = 8'h2b;  // +
  localparam logic [7:0] CH_NAK    = 8'h2d;  // -
  localparam logic [7:0] ESC_XOR   = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: h.val = 4'(c - 8'h30);
      [8'h61:8'h66]: h.val = 4'(c - 8'h57);
      [8'h41:8'h46]: h.val = 4'(c - 8'h37);
      default:       h.ok  = 1'b0;
    endcase
    return h;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_lower(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'd0, v};
    end else begin
      c = 8'h57 + {4'd0, v};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/rsp_packet_framer.sv
// ----------------------------------------------------------------------------
// rsp_packet_framer
// Frames and deframes "$payload#xx" serial debug packets one byte per item.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (cmd, data_byte)
//   out      output     out_valid_o / out_stall_i out_data_o (kind, out_byte,
//                                                   status, last_of_run)
//
// An item waits in the input register until the bank is free, then its 0 to 4
// results are worked out in one pass and loaded into the result register bank.
// The bank hands out one result per cycle while out_stall_i is low; items with
// one result run at one per cycle while out_stall_i is low.
// The input register takes one more item while the bank still drains, then stalls.
// Reset clears all framer state and empties both registers.
//
`default_nettype none

module rsp_packet_framer #(
  parameter int unsigned MaxPayload = rspf_pkg::MaxPayloadDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  rspf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output rspf_pkg::out_item_t out_data_o
);

  import rspf_pkg::*;

  localparam int unsigned SerialLimit = 2 * MaxPayload + 8;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_HEX1 = 2'd2;
  localparam logic [1:0] PH_HEX2 = 2'd3;

  // framer state
  logic [1:0]              rx_phase_q, rx_phase_d;
  logic                    rx_escape_q, rx_escape_d;
  logic [7:0]              rx_sum_q, rx_sum_d;
  logic [3:0]              rx_hi_q, rx_hi_d;
  logic [RxCountWidth-1:0] rx_count_q, rx_count_d;
  logic                    in_flight_q, in_flight_d;
  logic                    tx_started_q, tx_started_d;
  logic [7:0]              tx_sum_q, tx_sum_d;
  logic [TxCountWidth-1:0] tx_count_q, tx_count_d;

  // input register
  logic     in_vld_q;
  in_item_t in_q;

  // result bank
  out_item_t  bnd_q [MaxResults];
  logic [2:0] bnd_cnt_q;
  logic [1:0] bnd_idx_q;

  out_item_t  res [MaxResults];
  logic [2:0] res_n;

  logic take, last_take, bnd_free, advance, in_accept;

  assign out_valid_o = (bnd_cnt_q != 3'd0);
  assign out_data_o  = bnd_q[bnd_idx_q];
  assign take        = out_valid_o && !out_stall_i;
  assign last_take   = take && ({1'b0, bnd_idx_q} == (bnd_cnt_q - 3'd1));
  assign bnd_free    = (bnd_cnt_q == 3'd0) || last_take;
  assign advance     = in_vld_q && bnd_free;
  assign in_stall_o  = in_vld_q && !bnd_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  logic [7:0]  b;
  logic [7:0]  c;
  logic        special;
  hex_t        hx;
  logic [2:0]  fin_st;
  logic        fin;
  logic [2:0]  need;
  logic [12:0] tx_total;
  logic [7:0]  esc_b;

  always_comb begin
    b           = in_q.data_byte;
    c           = b;
    esc_b       = b ^ ESC_XOR;
    special     = (b == CH_START) || (b == CH_END) || (b == CH_STAR) || (b == CH_ESC);
    hx          = hex_decode(b);
    fin         = 1'b0;
    fin_st      = ST_GOOD;
    need        = 3'd0;
    tx_total    = 13'd0;
    res_n       = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end

    rx_phase_d   = rx_phase_q;
    rx_escape_d  = rx_escape_q;
    rx_sum_d     = rx_sum_q;
    rx_hi_d      = rx_hi_q;
    rx_count_d   = rx_count_q;
    in_flight_d  = in_flight_q;
    tx_started_d = tx_started_q;
    tx_sum_d     = tx_sum_q;
    tx_count_d   = tx_count_q;

    case (in_q.cmd)
      CMD_RX_BYTE: begin
        case (rx_phase_q)
          PH_HUNT: begin
            if (in_flight_q) begin
              if (b == CH_ACK) begin
                in_flight_d = 1'b0;
              end else if (b == CH_NAK) begin
                res[0].kind = KIND_RETX;
                res_n = 3'd1;
              end
            end else if (b == CH_START) begin
              rx_phase_d  = PH_DATA;
              rx_escape_d = 1'b0;
              rx_sum_d    = 8'd0;
              rx_count_d  = '0;
              rx_hi_d     = 4'd0;
            end else if (b == CH_INTR) begin
              res[0].kind     = KIND_RXBYTE;
              res[0].out_byte = CH_INTR;
              res[1].kind     = KIND_END;
              res[1].status   = ST_INTR;
              res_n = 3'd2;
            end
          end
          PH_DATA: begin
            if (b == CH_END) begin
              if (rx_escape_q) begin
                fin    = 1'b1;
                fin_st = ST_DANGLING;
              end else begin
                rx_phase_d = PH_HEX1;
              end
            end else begin
              rx_sum_d = rx_sum_q + b;
              if (rx_escape_q || b != CH_ESC) begin
                // escaped byte or plain byte goes out as data unless the payload limit is hit
                if (rx_escape_q) begin
                  c = esc_b;
                  rx_escape_d = 1'b0;
                end
                if (rx_count_q >= RxCountWidth'(MaxPayload)) begin
                  fin    = 1'b1;
                  fin_st = ST_TOO_LONG;
                end else begin
                  res[0].kind     = KIND_RXBYTE;
                  res[0].out_byte = c;
                  res_n = 3'd1;
                  rx_count_d = rx_count_q + 1'b1;
                end
              end else begin
                rx_escape_d = 1'b1;
              end
            end
          end
          PH_HEX1: begin
            if (!hx.ok) begin
              fin    = 1'b1;
              fin_st = ST_BAD_HEX;
            end else begin
              rx_hi_d    = hx.val;
              rx_phase_d = PH_HEX2;
            end
          end
          default: begin
            fin = 1'b1;
            if (!hx.ok) begin
              fin_st = ST_BAD_HEX;
            end else if ({rx_hi_q, hx.val} != rx_sum_q) begin
              fin_st = ST_BAD_SUM;
            end else begin
              fin_st = ST_GOOD;
            end
          end
        endcase
        if (fin) begin
          res[0].kind     = KIND_END;
          res[0].status   = fin_st;
          res[1].kind     = KIND_LINK;
          res[1].out_byte = (fin_st == ST_GOOD) ? CH_ACK : CH_NAK;
          res_n       = 3'd2;
          rx_phase_d  = PH_HUNT;
          rx_escape_d = 1'b0;
        end
      end
      CMD_TX_BYTE, CMD_TX_END: begin
        need = {2'b00, !tx_started_q}
             + ((in_q.cmd == CMD_TX_BYTE) ? (special ? 3'd2 : 3'd1) : 3'd3);
        tx_total = (tx_started_q ? {1'b0, tx_count_q} : 13'd0) + {10'd0, need};
        if (!tx_started_q && in_flight_q) begin
          res[0].kind = KIND_ERROR;
          res_n = 3'd1;
        end else if (tx_total > 13'(SerialLimit)) begin
          res[0].kind  = KIND_ERROR;
          res_n        = 3'd1;
          tx_started_d = 1'b0;
          tx_sum_d     = 8'd0;
          tx_count_d   = '0;
        end else begin
          // fresh packet opens with the start character
          if (!tx_started_q) begin
            tx_sum_d   = 8'd0;
            tx_count_d = TxCountWidth'(1);
          end
          if (in_q.cmd == CMD_TX_BYTE) begin
            if (special) begin
              tx_sum_d   = tx_sum_d + CH_ESC + esc_b;
              tx_count_d = tx_count_d + TxCountWidth'(2);
            end else begin
              tx_sum_d   = tx_sum_d + b;
              tx_count_d = tx_count_d + TxCountWidth'(1);
            end
            tx_started_d = 1'b1;
          end else begin
            tx_count_d   = tx_count_d + TxCountWidth'(3);
            tx_started_d = 1'b0;
            in_flight_d  = 1'b1;
          end
          // result slots start after the optional start character
          if (!tx_started_q) begin
            res[0].kind     = KIND_LINK;
            res[0].out_byte = CH_START;
          end
          if (in_q.cmd == CMD_TX_BYTE) begin
            if (special) begin
              res[{1'b0, !tx_started_q}].kind     = KIND_LINK;
              res[{1'b0, !tx_started_q}].out_byte = CH_ESC;
              res[{1'b0, !tx_started_q} + 2'd1].kind     = KIND_LINK;
              res[{1'b0, !tx_started_q} + 2'd1].out_byte = esc_b;
            end else begin
              res[{1'b0, !tx_started_q}].kind     = KIND_LINK;
              res[{1'b0, !tx_started_q}].out_byte = b;
            end
          end else begin
            res[{1'b0, !tx_started_q}].kind     = KIND_LINK;
            res[{1'b0, !tx_started_q}].out_byte = CH_END;
            res[{1'b0, !tx_started_q} + 2'd1].kind     = KIND_LINK;
            res[{1'b0, !tx_started_q} + 2'd1].out_byte = hex_lower(tx_sum_d[7:4]);
            res[{1'b0, !tx_started_q} + 2'd2].kind     = KIND_LINK;
            res[{1'b0, !tx_started_q} + 2'd2].out_byte = hex_lower(tx_sum_d[3:0]);
          end
          res_n = need;
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < MaxResults; i++) begin
      res[i].last_of_run = (3'(i) == (res_n - 3'd1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      bnd_cnt_q    <= 3'd0;
      bnd_idx_q    <= 2'd0;
      rx_phase_q   <= PH_HUNT;
      rx_escape_q  <= 1'b0;
      rx_sum_q     <= 8'd0;
      rx_hi_q      <= 4'd0;
      rx_count_q   <= '0;
      in_flight_q  <= 1'b0;
      tx_started_q <= 1'b0;
      tx_sum_q     <= 8'd0;
      tx_count_q   <= '0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        bnd_cnt_q    <= res_n;
        bnd_idx_q    <= 2'd0;
        rx_phase_q   <= rx_phase_d;
        rx_escape_q  <= rx_escape_d;
        rx_sum_q     <= rx_sum_d;
        rx_hi_q      <= rx_hi_d;
        rx_count_q   <= rx_count_d;
        in_flight_q  <= in_flight_d;
        tx_started_q <= tx_started_d;
        tx_sum_q     <= tx_sum_d;
        tx_count_q   <= tx_count_d;
      end else if (last_take) begin
        bnd_cnt_q <= 3'd0;
        bnd_idx_q <= 2'd0;
      end else if (take) begin
        bnd_idx_q <= bnd_idx_q + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      for (int i = 0; i < MaxResults; i++) begin
        bnd_q[i] <= res[i];
      end
    end
  end

endmodule

`default_nettype wire
